FILE: hdl/url_percent_codec_top_defines.svh
// Assertion macros shared by the codec modules
`ifndef URL_PERCENT_CODEC_TOP_DEFINES_SVH
`define URL_PERCENT_CODEC_TOP_DEFINES_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define UPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define UPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/upc_pkg.sv
package upc_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);
	localparam int unsigned QCW = QAW + 1;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(1);

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [2:0] MODE_NONE = 3'd0;
	localparam logic [2:0] MODE_PATH = 3'd1;
	localparam logic [2:0] MODE_SEGMENT = 3'd2;
	localparam logic [2:0] MODE_HOST = 3'd3;
	localparam logic [2:0] MODE_ZONE = 3'd4;
	localparam logic [2:0] MODE_USERINFO = 3'd5;
	localparam logic [2:0] MODE_QUERY = 3'd6;
	localparam logic [2:0] MODE_FRAGMENT = 3'd7;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW = 2'd2;

	localparam logic [1:0] PIECE_PCT = 2'd0;
	localparam logic [1:0] PIECE_HI = 2'd1;
	localparam logic [1:0] PIECE_LO = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} upc_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       bad_escape;
	} upc_rsp_t;

	typedef struct packed {
		logic       esc;
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       bad;
	} upc_cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} upc_hex_t;

	function automatic logic must_escape(input logic [7:0] b, input logic [2:0] mode);
		logic alnum;
		logic host_ok;
		logic unres;
		logic subd;
		logic res;
		alnum = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
		host_ok = b == "!" || b == "$" || b == "&" || b == "'" || b == "(" || b == ")" ||
			b == "*" || b == "+" || b == "," || b == ";" || b == "=" || b == ":" ||
			b == "[" || b == "]" || b == "<" || b == ">" || b == "\"";
		unres = b == "-" || b == "_" || b == "." || b == "~";
		subd = b == "$" || b == "&" || b == "+" || b == "," || b == "/" || b == ":" ||
			b == ";" || b == "=" || b == "?" || b == "@";
		res = 1'b1;
		if (alnum) begin
			res = 1'b0;
		end else if ((mode == MODE_HOST || mode == MODE_ZONE) && host_ok) begin
			res = 1'b0;
		end else if (unres) begin
			res = 1'b0;
		end else if (subd && mode != MODE_NONE && mode != MODE_HOST && mode != MODE_ZONE) begin
			unique case (mode)
				MODE_PATH:     res = (b == "?");
				MODE_SEGMENT:  res = (b == "/" || b == ";" || b == "," || b == "?");
				MODE_USERINFO: res = (b == "@" || b == "/" || b == "?" || b == ":");
				MODE_QUERY:    res = 1'b1;
				default:       res = 1'b0;
			endcase
		end else if (mode == MODE_FRAGMENT && (b == "!" || b == "(" || b == ")" || b == "*")) begin
			res = 1'b0;
		end
		return res;
	endfunction

	function automatic upc_hex_t hex_value(input logic [7:0] b);
		upc_hex_t h;
		h.ok = 1'b1;
		h.nib = 4'd0;
		if (b >= "0" && b <= "9") begin
			h.nib = 4'(b - "0");
		end else if (b >= "a" && b <= "f") begin
			h.nib = 4'(b - "a" + 8'd10);
		end else if (b >= "A" && b <= "F") begin
			h.nib = 4'(b - "A" + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = "0" + {4'd0, n};
		end else begin
			c = "A" - 8'd10 + {4'd0, n};
		end
		return c;
	endfunction

endpackage

FILE: hdl/upc_front.sv
module upc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_stall,
	input  upc_pkg::upc_req_t                req,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [upc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [upc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             push,
	output upc_pkg::upc_cmd_t                push_cmd
);

	logic        direction_q;
	logic [2:0]  mode_q;
	logic [1:0]  phase_q;
	logic [3:0]  hi_q;
	logic        err_q;

	logic [1:0]  phase_n;
	logic [3:0]  hi_n;
	logic        err_n;
	logic        emit;
	logic [7:0]  ob;
	logic        err_f;
	logic        accept;
	logic [7:0]  b;
	logic [7:0]  v;
	logic        is25;
	upc_pkg::upc_hex_t hv;

	assign accept = req_valid && !req_stall;
	assign b = req.in_byte;
	assign hv = upc_pkg::hex_value(b);
	assign v = {hi_q, hv.nib};
	assign is25 = (hi_q == 4'd2) && (b == "5");

	always_comb begin
		phase_n = phase_q;
		hi_n = hi_q;
		err_n = err_q;
		emit = 1'b0;
		ob = 8'd0;
		if (!err_q) begin
			unique case (phase_q)
				upc_pkg::PH_IDLE: begin
					if (b == upc_pkg::CH_PERCENT) begin
						phase_n = upc_pkg::PH_HIGH;
					end else if (b == upc_pkg::CH_PLUS) begin
						emit = 1'b1;
						ob = (mode_q == upc_pkg::MODE_QUERY) ? upc_pkg::CH_SPACE : upc_pkg::CH_PLUS;
					end else if ((mode_q == upc_pkg::MODE_HOST || mode_q == upc_pkg::MODE_ZONE) &&
							!b[7] && upc_pkg::must_escape(b, mode_q)) begin
						err_n = 1'b1;
					end else begin
						emit = 1'b1;
						ob = b;
					end
				end
				upc_pkg::PH_HIGH: begin
					if (!hv.ok) begin
						err_n = 1'b1;
					end else begin
						hi_n = hv.nib;
						phase_n = upc_pkg::PH_LOW;
					end
				end
				default: begin
					if (!hv.ok) begin
						err_n = 1'b1;
					end else begin
						if (mode_q == upc_pkg::MODE_HOST && !hi_q[3] && !is25) begin
							err_n = 1'b1;
						end else if (mode_q == upc_pkg::MODE_ZONE && !is25 && v != upc_pkg::CH_SPACE &&
								upc_pkg::must_escape(v, upc_pkg::MODE_HOST)) begin
							err_n = 1'b1;
						end else begin
							emit = 1'b1;
							ob = v;
						end
						phase_n = upc_pkg::PH_IDLE;
					end
				end
			endcase
		end
		err_f = err_n || (phase_n != upc_pkg::PH_IDLE);
	end

	always_comb begin
		push_cmd = '0;
		push = 1'b0;
		if (direction_q == upc_pkg::DIR_ENCODE) begin
			push = accept;
			push_cmd.valid = 1'b1;
			push_cmd.last = req.end_of_string;
			if (b == upc_pkg::CH_SPACE && mode_q == upc_pkg::MODE_QUERY) begin
				push_cmd.data = upc_pkg::CH_PLUS;
			end else begin
				push_cmd.data = b;
				push_cmd.esc = upc_pkg::must_escape(b, mode_q);
			end
		end else begin
			push = accept && (emit || req.end_of_string);
			push_cmd.valid = emit;
			push_cmd.data = ob;
			push_cmd.last = req.end_of_string;
			push_cmd.bad = req.end_of_string && err_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= upc_pkg::DIR_ENCODE;
			mode_q <= upc_pkg::MODE_QUERY;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == upc_pkg::CFG_DIRECTION) begin
				direction_q <= cfg_data[0];
			end else if (cfg_index == upc_pkg::CFG_MODE) begin
				mode_q <= cfg_data[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upc_pkg::PH_IDLE;
			hi_q <= 4'd0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (req.end_of_string) begin
				phase_q <= upc_pkg::PH_IDLE;
				hi_q <= 4'd0;
				err_q <= 1'b0;
			end else if (direction_q == upc_pkg::DIR_DECODE) begin
				phase_q <= phase_n;
				hi_q <= hi_n;
				err_q <= err_n;
			end
		end
	end

endmodule

FILE: hdl/upc_fifo.sv
`include "url_percent_codec_top_defines.svh"

module upc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upc_pkg::upc_cmd_t push_cmd,
	input  logic              pop,
	output upc_pkg::upc_cmd_t head,
	output logic              empty,
	output logic              full
);

	upc_pkg::upc_cmd_t             slot_q [upc_pkg::QDEPTH];
	logic [upc_pkg::QAW-1:0]       wr_ptr_q;
	logic [upc_pkg::QAW-1:0]       rd_ptr_q;
	logic [upc_pkg::QCW-1:0]       count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == upc_pkg::QCW'(upc_pkg::QDEPTH));
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`UPC_ASSERT_SAME(a_no_push_full, clk, arst_n, full, !push, "request pushed into full queue")
	`UPC_ASSERT_SAME(a_no_pop_empty, clk, arst_n, empty, !pop, "request popped from empty queue")
	`UPC_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1,
		count_q <= upc_pkg::QCW'(upc_pkg::QDEPTH), "queue count beyond depth")

endmodule

FILE: hdl/upc_back.sv
`include "url_percent_codec_top_defines.svh"

module upc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  upc_pkg::upc_cmd_t head,
	input  logic              empty,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output upc_pkg::upc_rsp_t rsp
);

	logic [1:0]        piece_q;
	logic              rsp_valid_q;
	upc_pkg::upc_rsp_t rsp_q;
	logic              load;
	logic              fire;
	logic              final_piece;
	logic [7:0]        pbyte;

	assign load = !rsp_valid_q || !rsp_stall;
	assign fire = load && !empty;
	assign final_piece = !head.esc || (piece_q == upc_pkg::PIECE_LO);
	assign pop = fire && final_piece;

	always_comb begin
		pbyte = head.data;
		if (head.esc) begin
			unique case (piece_q)
				upc_pkg::PIECE_PCT: pbyte = upc_pkg::CH_PERCENT;
				upc_pkg::PIECE_HI:  pbyte = upc_pkg::hex_char(head.data[7:4]);
				default:            pbyte = upc_pkg::hex_char(head.data[3:0]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_q <= upc_pkg::PIECE_PCT;
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= !empty;
			if (fire) begin
				piece_q <= final_piece ? upc_pkg::PIECE_PCT : piece_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.out_byte <= pbyte;
			rsp_q.byte_valid <= head.valid;
			rsp_q.run_last <= head.last && final_piece;
			rsp_q.bad_escape <= head.bad && final_piece;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`UPC_ASSERT_SAME(a_piece_esc, clk, arst_n, piece_q != upc_pkg::PIECE_PCT,
		!empty && head.esc, "escape piece count without escape request")
	`UPC_ASSERT_SAME(a_bad_on_last, clk, arst_n, rsp_valid_q && rsp_q.bad_escape,
		rsp_q.run_last, "error flag on a result that does not end the string")
	`UPC_ASSERT_NEXT(a_esc_advance, clk, arst_n, fire && !final_piece,
		piece_q != upc_pkg::PIECE_PCT, "escape piece did not advance")

endmodule

FILE: hdl/url_percent_codec_top.sv
// Streaming URL percent codec. Each request carries one byte of a string;
// configure direction (index 0) and component mode (index 1) only while idle,
// cfg_ready is always high. A front stage classifies each byte and tracks the
// decode escape state, pushing at most one entry into a four-deep queue; a
// back stage expands queue entries into results behind an output register.
// Encoding a byte that needs a %XY escape makes the back stage emit three
// bytes: the percent sign, then the high and low hex digits; every other
// entry yields one result, and decode bytes that open or continue an escape
// push no entry unless they end the string. Input runs at one byte per cycle
// unless req_stall or rsp_stall holds it, bounded by the back-stage output.
module url_percent_codec_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  upc_pkg::upc_req_t              req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output upc_pkg::upc_rsp_t              rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [upc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [upc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic              push;
	upc_pkg::upc_cmd_t push_cmd;
	logic              pop;
	upc_pkg::upc_cmd_t head;
	logic              empty;
	logic              full;

	assign cfg_ready = 1'b1;
	assign req_stall = full;

	upc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	upc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	upc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
